// ===== hdl/msd_pkg.sv =====
// ============================================================================
// msd_pkg: shared types and constants for the mean and standard deviation core
// Holds the request and result payload structs and the default sample bound.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

    // Default bound on the number of samples counted in one set.
    localparam int DEF_MAX_SAMPLES = 1024;

    // Fixed field widths of the payloads.
    localparam int SAMPLE_W = 16;
    localparam int STD_W    = 15;
    localparam int COUNT_W  = 11;

    // One input request: a Q8.8 sample and the end-of-set flag.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in_item;

    // One result request, given at the end of a set.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic [STD_W-1:0]           std_dev;
        logic [COUNT_W-1:0]         sample_count;
        logic                       overflow;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/msd_alu.sv =====
// ============================================================================
// msd_alu: shared add/subtract unit
// Adds or subtracts two unsigned words; on subtract the carry out is high
// exactly when a >= b, which the sequencer uses as its compare result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module msd_alu #(
    parameter int W = 64
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic         i_sub,
    output logic [W-1:0]      o_res,
    output logic              o_carry
);

    logic [W-1:0] b_eff;
    logic [W:0]   full;

    // Two's complement subtract is add of the inverted operand plus one.
    assign b_eff = i_sub ? ~i_b : i_b;
    assign full  = {1'b0, i_a} + {1'b0, b_eff} + {{W{1'b0}}, i_sub};

    assign o_res   = full[W-1:0];
    assign o_carry = full[W];

endmodule

`default_nettype wire

// ===== hdl/mean_and_std_deviation_core.sv =====
// ============================================================================
// mean_and_std_deviation_core: population mean and standard deviation
// Accumulates count, sum and sum of squares of Q8.8 samples; on the last
// sample of a set it derives mean and standard deviation with one shared
// add/subtract unit run by a small sequencer.
// ============================================================================
// Flow: a counted sample is accepted, added to the sum, then its square is added
//   (both adds share one ALU) before the next sample is accepted; a sample beyond
//   MAX_SAMPLES is only accepted and flags overflow. A last request then runs the
//   magnitude, multiply, root and two divide steps and waits until the result
//   register is free; a last request beyond the bound skips both adds.
// Reset: synchronous active-low i_rst_n clears accumulators, sequencer, valid.
`timescale 1ns / 1ps
`default_nettype none

module mean_and_std_deviation_core #(
    parameter int MAX_SAMPLES = msd_pkg::DEF_MAX_SAMPLES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire msd_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output msd_pkg::t_out_item     o_out_data
);

    // Derived widths.
    localparam int L   = $clog2(MAX_SAMPLES);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);  // sample count
    localparam int SW  = 16 + L;                   // signed running sum
    localparam int QW  = 31 + L;                   // running sum of squares
    localparam int MW  = 16 + L;                   // |sum|, root and quotients
    localparam int DW  = 31 + 2 * L;               // n*sumsq - sum^2
    localparam int SCW = $clog2(MW);               // step counter
    localparam int XW  = msd_pkg::SAMPLE_W;

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SUM  = 4'd1;
    localparam logic [3:0] S_SQS  = 4'd2;
    localparam logic [3:0] S_MAG  = 4'd3;
    localparam logic [3:0] S_MULA = 4'd4;
    localparam logic [3:0] S_MULS = 4'd5;
    localparam logic [3:0] S_SQRT = 4'd6;
    localparam logic [3:0] S_DIVM = 4'd7;
    localparam logic [3:0] S_DIVS = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    localparam logic [CW-1:0]  MAX_CNT   = CW'(MAX_SAMPLES);
    localparam logic [SCW-1:0] STEPS_CNT = SCW'(CW - 1);
    localparam logic [SCW-1:0] STEPS_MW  = SCW'(MW - 1);

    logic [3:0]          r_state, n_state;
    logic signed [SW-1:0] r_sum, n_sum;
    logic [QW-1:0]       r_sq_sum, n_sq_sum;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_over, n_over;
    logic [XW-1:0]       r_x, n_x;
    logic                r_last, n_last;
    logic [30:0]         r_sqr, n_sqr;
    logic [MW-1:0]       r_mag, n_mag;
    logic [DW-1:0]       r_acc, n_acc;
    logic [DW-1:0]       r_mcand, n_mcand;
    logic [DW-1:0]       r_bit, n_bit;
    logic [MW-1:0]       r_mplier, n_mplier;
    logic [SCW-1:0]      r_step, n_step;
    logic [XW-1:0]       r_mean, n_mean;
    logic                r_out_valid, n_out_valid;
    msd_pkg::t_out_item  r_out, n_out;

    logic [DW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub, alu_carry;
    logic          in_fire, out_free, sum_neg, step_end;
    logic [DW-1:0] div_t, sum_ext, cnt_ext;
    logic [MW-1:0] div_q;
    logic signed [2*XW-1:0] x_sq;
    logic [31:0]   cnt_wide;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign sum_neg  = r_sum[SW-1];
    assign step_end = (r_step == '0);
    assign sum_ext  = {{(DW-SW){r_sum[SW-1]}}, r_sum};
    assign cnt_ext  = {{(DW-CW){1'b0}}, r_cnt};
    assign div_t    = {r_acc[DW-2:0], r_mplier[MW-1]};
    assign div_q    = {r_mplier[MW-2:0], alu_carry};
    assign x_sq     = $signed(r_x) * $signed(r_x);
    assign cnt_wide = 32'(r_cnt);

    // Shared add/subtract unit.
    msd_alu #(
        .W (DW)
    ) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_res   (alu_res),
        .o_carry (alu_carry)
    );

    // ALU operand selection for each sequencer step.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state) inside
            S_SUM: begin
                alu_a = {{(DW-XW){r_x[XW-1]}}, r_x};
                alu_b = sum_ext;
            end
            S_SQS: begin
                alu_a = {{(DW-QW){1'b0}}, r_sq_sum};
                alu_b = {{(DW-31){1'b0}}, r_sqr};
            end
            S_MAG: begin
                alu_a   = sum_neg ? '0 : sum_ext;
                alu_b   = sum_neg ? sum_ext : '0;
                alu_sub = sum_neg;
            end
            S_MULA: begin
                alu_a = r_acc;
                alu_b = r_mplier[0] ? r_mcand : '0;
            end
            S_MULS: begin
                alu_a   = r_acc;
                alu_b   = r_mplier[0] ? r_mcand : '0;
                alu_sub = 1'b1;
            end
            S_SQRT: begin
                alu_a   = r_acc;
                alu_b   = r_mcand | r_bit;
                alu_sub = 1'b1;
            end
            S_DIVM, S_DIVS: begin
                alu_a   = div_t;
                alu_b   = cnt_ext;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_sq_sum    = r_sq_sum;
        n_cnt       = r_cnt;
        n_over      = r_over;
        n_x         = r_x;
        n_last      = r_last;
        n_sqr       = r_sqr;
        n_mag       = r_mag;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_bit       = r_bit;
        n_mplier    = r_mplier;
        n_step      = r_step;
        n_mean      = r_mean;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_x    = i_in_data.sample;
                    n_last = i_in_data.last;
                    if (r_cnt < MAX_CNT) begin
                        n_state = S_SUM;
                    end else begin
                        n_over  = 1'b1;
                        n_state = i_in_data.last ? S_MAG : S_IDLE;
                    end
                end
            end
            S_SUM: begin
                n_sum   = alu_res[SW-1:0];
                n_sqr   = x_sq[30:0];
                n_state = S_SQS;
            end
            S_SQS: begin
                n_sq_sum = alu_res[QW-1:0];
                n_cnt    = r_cnt + 1'b1;
                n_state  = r_last ? S_MAG : S_IDLE;
            end
            S_MAG: begin
                // Magnitude of the sum, then set up n * sumsq.
                n_mag    = alu_res[MW-1:0];
                n_acc    = '0;
                n_mcand  = {{(DW-QW){1'b0}}, r_sq_sum};
                n_mplier = {{(MW-CW){1'b0}}, r_cnt};
                n_step   = STEPS_CNT;
                n_state  = S_MULA;
            end
            S_MULA: begin
                n_acc    = alu_res;
                n_mcand  = {r_mcand[DW-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[MW-1:1]};
                n_step   = r_step - 1'b1;
                if (step_end) begin
                    // Subtract |sum|^2 from the product next.
                    n_mcand  = {{(DW-MW){1'b0}}, r_mag};
                    n_mplier = r_mag;
                    n_step   = STEPS_MW;
                    n_state  = S_MULS;
                end
            end
            S_MULS: begin
                n_acc    = alu_res;
                n_mcand  = {r_mcand[DW-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[MW-1:1]};
                n_step   = r_step - 1'b1;
                if (step_end) begin
                    n_mcand = '0;
                    n_bit   = {1'b1, {(DW-1){1'b0}}};
                    n_step  = STEPS_MW;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                // One result bit per step of the digit-by-digit root.
                if (alu_carry) begin
                    n_acc   = alu_res;
                    n_mcand = {1'b0, r_mcand[DW-1:1]} | r_bit;
                end else begin
                    n_mcand = {1'b0, r_mcand[DW-1:1]};
                end
                n_bit  = {2'b00, r_bit[DW-1:2]};
                n_step = r_step - 1'b1;
                if (step_end) begin
                    n_acc    = '0;
                    n_mplier = r_mag;
                    n_step   = STEPS_MW;
                    n_state  = S_DIVM;
                end
            end
            S_DIVM: begin
                // Restoring divide of |sum| by the count.
                n_acc    = alu_carry ? alu_res : div_t;
                n_mplier = div_q;
                n_step   = r_step - 1'b1;
                if (step_end) begin
                    n_mean   = sum_neg ? (XW'(0) - div_q[XW-1:0]) : div_q[XW-1:0];
                    n_acc    = '0;
                    n_mplier = r_mcand[MW-1:0];
                    n_step   = STEPS_MW;
                    n_state  = S_DIVS;
                end
            end
            S_DIVS: begin
                // Restoring divide of the root by the count.
                n_acc    = alu_carry ? alu_res : div_t;
                n_mplier = div_q;
                n_step   = r_step - 1'b1;
                if (step_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Load the result register once it is free, then clear the set.
                if (out_free) begin
                    n_out.mean         = r_mean;
                    n_out.std_dev      = r_mplier[msd_pkg::STD_W-1:0];
                    n_out.sample_count = cnt_wide[msd_pkg::COUNT_W-1:0];
                    n_out.overflow     = r_over;
                    n_out_valid        = 1'b1;
                    n_sum              = '0;
                    n_sq_sum           = '0;
                    n_cnt              = '0;
                    n_over             = 1'b0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and accumulator registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_sq_sum    <= '0;
            r_cnt       <= '0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_sq_sum    <= n_sq_sum;
            r_cnt       <= n_cnt;
            r_over      <= n_over;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_last   <= n_last;
        r_sqr    <= n_sqr;
        r_mag    <= n_mag;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_bit    <= n_bit;
        r_mplier <= n_mplier;
        r_mean   <= n_mean;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // The count never passes the bound.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("sample count above bound");

    // Overflow is only flagged once the count has saturated.
    a_over_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_over |-> (r_cnt == MAX_CNT))
        else $error("overflow flag without saturated count");

    // Finishing a set shows a result and clears the count and overflow flag.
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out_valid && r_cnt == '0 && !r_over))
        else $error("set finished without result or clear");
`endif

endmodule

`default_nettype wire
